### hdl/sewd_pkg.sv
// Shared field widths, request codes and reply codes for the sensor event waiter.
package sewd_pkg;

  // Port field widths
  localparam int REQ_W   = 3;
  localparam int SIDX_W  = 7;
  localparam int TIME_W  = 32;
  localparam int TASK_W  = 8;
  localparam int TIDX_W  = 3;
  localparam int OWNER_W = 4;
  localparam int KIND_W  = 2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_EVENT       = 3'd0,
    REQ_WAIT_SENSOR = 3'd1,
    REQ_WAIT_ANY    = 3'd2,
    REQ_WAIT_TRAIN  = 3'd3,
    REQ_CANCEL      = 3'd4
  } req_t;

  // Reply codes
  localparam logic [KIND_W-1:0] KIND_HIT      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OCCUPIED = 2'd2;

endpackage

### hdl/sensor_event_waiter_dispatch.sv
// Top level of the sensor event waiter: slot tables, request decode and reply register.
//
//  channel | signals                                   | dir | accepted when
//  --------+-------------------------------------------+-----+------------------------
//  request | req_type sensor_index event_time requester | in  | in_valid & in_ready
//          | train_index owner_train                   |     |
//  reply   | notify_task reply_kind hit_time hit_sensor | out | out_valid & out_ready
//
// Each item is accepted in the idle state, where the accept edge starts the slot memory
// reads; in the exec state the block reads, decides, writes back and loads the reply register.
// A new request is accepted only in the idle state, after the current item has committed.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// A full reply register that is not taken holds the decide stage, and with it
// the request side, until the reply leaves.
module sensor_event_waiter_dispatch #(
  parameter int SENSOR_COUNT = 80,
  parameter int TRAIN_COUNT  = 8,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sewd_pkg::REQ_W-1:0]    req_type,
  input  logic [sewd_pkg::SIDX_W-1:0]   sensor_index,
  input  logic [sewd_pkg::TIME_W-1:0]   event_time,
  input  logic [sewd_pkg::TASK_W-1:0]   requester,
  input  logic [sewd_pkg::TIDX_W-1:0]   train_index,
  input  logic signed [sewd_pkg::OWNER_W-1:0] owner_train,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sewd_pkg::TASK_W-1:0]   notify_task,
  output logic [sewd_pkg::KIND_W-1:0]   reply_kind,
  output logic [sewd_pkg::TIME_W-1:0]   hit_time,
  output logic [sewd_pkg::SIDX_W-1:0]   hit_sensor
);

  import sewd_pkg::*;

  localparam int SAW   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int TAW   = (TRAIN_COUNT > 1) ? $clog2(TRAIN_COUNT) : 1;
  localparam int EXT_W = (TASK_ID_BITS > TASK_W) ? TASK_ID_BITS : TASK_W;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // Registered request
  logic [REQ_W-1:0]        r_type;
  logic [SIDX_W-1:0]       r_sidx;
  logic [TIME_W-1:0]       r_time;
  logic [TASK_ID_BITS-1:0] r_tid;
  logic                    r_s_ok;
  logic                    r_t_ok;
  logic [SAW-1:0]          r_saddr;
  logic [TAW-1:0]          r_taddr;

  // Slot valid bits and the any-waiter
  logic [SENSOR_COUNT-1:0] sensor_valid;
  logic [TRAIN_COUNT-1:0]  train_valid;
  logic                    any_valid;
  logic [TASK_ID_BITS-1:0] any_task;

  // Request decode at accept
  logic [8:0]              sidx_ext;
  logic [EXT_W-1:0]        req_ext;
  logic [TASK_ID_BITS-1:0] tid;
  logic                    s_ok;
  logic                    owner_ok;
  logic                    tidx_ok;
  logic [TIDX_W-1:0]       tsel;
  logic [6:0]              tsel_ext;
  logic [SAW-1:0]          saddr;
  logic [TAW-1:0]          taddr;
  logic                    accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign sidx_ext = 9'(sensor_index);
  assign s_ok     = sidx_ext < 9'(SENSOR_COUNT);
  assign saddr    = sidx_ext[SAW-1:0];
  assign req_ext  = EXT_W'(requester);
  assign tid      = req_ext[TASK_ID_BITS-1:0];
  assign owner_ok = !owner_train[OWNER_W-1]
                    && (7'(owner_train[OWNER_W-2:0]) < 7'(TRAIN_COUNT));
  assign tidx_ok  = 7'(train_index) < 7'(TRAIN_COUNT);
  // Events look up the owning train, wait-train requests their own slot
  assign tsel     = (req_type == REQ_EVENT) ? TIDX_W'(owner_train[OWNER_W-2:0]) : train_index;
  assign tsel_ext = 7'(tsel);
  assign taddr    = tsel_ext[TAW-1:0];

  // Slot memories: read address follows the input while idle, the held request otherwise
  logic [TASK_ID_BITS-1:0] s_rdata;
  logic [TASK_ID_BITS-1:0] t_rdata;
  logic                    s_we;
  logic                    t_we;

  sewd_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (SENSOR_COUNT)
  ) u_sensor_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (r_saddr),
    .wdata (r_tid),
    .raddr ((state == ST_IDLE) ? saddr : r_saddr),
    .rdata (s_rdata)
  );

  sewd_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (TRAIN_COUNT)
  ) u_train_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (r_taddr),
    .wdata (r_tid),
    .raddr ((state == ST_IDLE) ? taddr : r_taddr),
    .rdata (t_rdata)
  );

  // Decide stage
  logic                    commit;
  logic                    s_occ;
  logic                    t_occ;
  logic                    res_valid;
  logic [TASK_ID_BITS-1:0] res_task;
  logic [KIND_W-1:0]       res_kind;
  logic [TIME_W-1:0]       res_time;
  logic [SIDX_W-1:0]       res_sensor;
  logic                    s_clr;
  logic                    t_clr;
  logic                    s_set;
  logic                    t_set;
  logic                    any_clr;
  logic                    any_set;
  logic [EXT_W-1:0]        res_ext;

  assign commit = (state == ST_EXEC) && (!out_valid || out_ready);
  assign s_occ  = r_s_ok ? sensor_valid[r_saddr] : 1'b0;
  assign t_occ  = r_t_ok ? train_valid[r_taddr] : 1'b0;

  always_comb begin
    res_valid  = 1'b0;
    res_task   = r_tid;
    res_kind   = KIND_REJECT;
    res_time   = '0;
    res_sensor = '0;
    s_clr      = 1'b0;
    t_clr      = 1'b0;
    s_set      = 1'b0;
    t_set      = 1'b0;
    any_clr    = 1'b0;
    any_set    = 1'b0;
    case (req_t'(r_type))
      REQ_EVENT: begin
        res_kind   = KIND_HIT;
        res_time   = r_time;
        res_sensor = r_sidx;
        // events on a sensor out of range wake nobody
        if (!r_s_ok) begin
          res_valid = 1'b0;
        end else if (s_occ) begin
          res_valid = 1'b1;
          res_task  = s_rdata;
          s_clr     = 1'b1;
        end else if (t_occ) begin
          res_valid = 1'b1;
          res_task  = t_rdata;
          t_clr     = 1'b1;
        end else if (any_valid) begin
          res_valid = 1'b1;
          res_task  = any_task;
          any_clr   = 1'b1;
        end
      end
      REQ_WAIT_SENSOR: begin
        res_sensor = r_sidx;
        if (!r_s_ok || s_occ) begin
          res_valid = 1'b1;
        end else begin
          s_set = 1'b1;
        end
      end
      REQ_WAIT_ANY: begin
        // old any-waiter is evicted with a rejection
        res_valid = any_valid;
        res_task  = any_task;
        any_set   = 1'b1;
      end
      REQ_WAIT_TRAIN: begin
        if (!r_t_ok) begin
          res_valid = 1'b1;
        end else if (t_occ) begin
          res_valid = 1'b1;
          res_kind  = KIND_OCCUPIED;
        end else begin
          t_set = 1'b1;
        end
      end
      REQ_CANCEL: begin
        res_sensor = r_sidx;
        if (s_occ && (s_rdata == r_tid)) begin
          res_valid = 1'b1;
          s_clr     = 1'b1;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign s_we    = commit && s_set;
  assign t_we    = commit && t_set;
  assign res_ext = EXT_W'(res_task);

  // State, slot flags and reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sensor_valid <= '0;
      train_valid  <= '0;
      any_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // reply taken and no new one loaded behind it
      if (out_valid && out_ready && !(commit && res_valid)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state <= ST_IDLE;
            if (s_clr) begin
              sensor_valid[r_saddr] <= 1'b0;
            end
            if (s_set) begin
              sensor_valid[r_saddr] <= 1'b1;
            end
            if (t_clr) begin
              train_valid[r_taddr] <= 1'b0;
            end
            if (t_set) begin
              train_valid[r_taddr] <= 1'b1;
            end
            if (any_clr) begin
              any_valid <= 1'b0;
            end
            if (any_set) begin
              any_valid <= 1'b1;
            end
            if (res_valid) begin
              out_valid <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      r_type  <= req_type;
      r_sidx  <= sensor_index;
      r_time  <= event_time;
      r_tid   <= tid;
      r_s_ok  <= s_ok;
      r_t_ok  <= (req_type == REQ_EVENT) ? owner_ok : tidx_ok;
      r_saddr <= saddr;
      r_taddr <= taddr;
    end
    if (commit && any_set) begin
      any_task <= r_tid;
    end
    if (commit && res_valid) begin
      notify_task <= res_ext[TASK_W-1:0];
      reply_kind  <= res_kind;
      hit_time    <= res_time;
      hit_sensor  <= res_sensor;
    end
  end

endmodule

### hdl/sewd_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
module sewd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
